// ----- rtl/syb_pkg.sv -----
`default_nettype none
package syb_pkg;

    localparam int POS_WIDTH_DEF    = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int BASIS_W  = 15;          // Q1.14 basis components
    localparam int SQ_W     = 30;          // sum of three basis squares
    localparam int RT_W     = SQ_W + 1;    // isqrt remainder / partial root
    localparam int LEN_W    = 15;          // final root width
    localparam int SQRT_STEPS     = 16;
    localparam int SQRT_PER_STAGE = 4;
    localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

    localparam int NORM_W   = 30;          // magnitudes held below 2^30
    localparam int CW       = 33;          // CORDIC x/y width
    localparam int ZW       = 33;          // angle accumulator width
    localparam int ATAN_W   = 29;
    localparam int MAXYAW_W = 15;
    localparam int TOL_W    = 8;
    localparam int YAW_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [31:0] HALF_TURN_FX = 32'd1179648000;
    localparam int          YAW_LIM      = 18000;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ABS_YAW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLATTEN_Z      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TOLERANCE = 2'd2;

    typedef struct packed {
        logic adv;
        logic vld;
    } t_pipe_ctl;

    typedef struct packed {
        logic [RT_W-1:0] v;
        logic [RT_W-1:0] res;
    } t_sqrt;

    function automatic t_sqrt sqrt_step(input t_sqrt s, input int unsigned j);
        logic [RT_W-1:0] pw;
        logic [RT_W-1:0] t;
        t_sqrt           r;
        pw = RT_W'(1) << (SQ_W - 2 * j);
        t  = s.res + pw;
        if (s.v >= t) begin
            r.v   = s.v - t;
            r.res = (s.res >> 1) + pw;
        end else begin
            r.v   = s.v;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    // atan(2^-i) in 1/65536 centidegree
    function automatic logic [ATAN_W-1:0] atan_entry(input int unsigned i);
        logic [ATAN_W-1:0] a;
        unique case (i)
            0:  a = 29'd294912000;
            1:  a = 29'd174096719;
            2:  a = 29'd91987925;
            3:  a = 29'd46694507;
            4:  a = 29'd23437865;
            5:  a = 29'd11730358;
            6:  a = 29'd5866610;
            7:  a = 29'd2933484;
            8:  a = 29'd1466764;
            9:  a = 29'd733385;
            10: a = 29'd366693;
            11: a = 29'd183346;
            12: a = 29'd91673;
            13: a = 29'd45837;
            14: a = 29'd22918;
            15: a = 29'd11459;
            16: a = 29'd5730;
            17: a = 29'd2865;
            18: a = 29'd1432;
            19: a = 29'd716;
            20: a = 29'd358;
            21: a = 29'd179;
            22: a = 29'd90;
            23: a = 29'd45;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/syb_isqrt.sv -----
`default_nettype none
module syb_isqrt
    import syb_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_pipe_ctl         i_ctl,
    input  wire logic [SQ_W-1:0]   i_sf,
    input  wire logic [SQ_W-1:0]   i_sr,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_vld,
    output logic [LEN_W-1:0]       o_nf,
    output logic [LEN_W-1:0]       o_nr,
    output logic [SIDE_W-1:0]      o_side
);

    t_sqrt             r_f    [SQRT_STAGES];
    t_sqrt             r_r    [SQRT_STAGES];
    logic [SIDE_W-1:0] r_side [SQRT_STAGES];
    logic              r_vld  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        t_sqrt n_f;
        t_sqrt n_r;
        always_comb begin
            t_sqrt f;
            t_sqrt r;
            if (k == 0) begin
                f.v = RT_W'(i_sf); f.res = '0;
                r.v = RT_W'(i_sr); r.res = '0;
            end else begin
                f = r_f[k-1];
                r = r_r[k-1];
            end
            for (int j = 0; j < SQRT_PER_STAGE; j++) begin
                f = sqrt_step(f, k * SQRT_PER_STAGE + j);
                r = sqrt_step(r, k * SQRT_PER_STAGE + j);
            end
            n_f = f;
            n_r = r;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.adv) begin
                r_vld[k] <= (k == 0) ? i_ctl.vld : r_vld[k-1];
            end
            if (i_ctl.adv) begin
                r_f[k]    <= n_f;
                r_r[k]    <= n_r;
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_nf   = r_f[SQRT_STAGES-1].res[LEN_W-1:0];
    assign o_nr   = r_r[SQRT_STAGES-1].res[LEN_W-1:0];
    assign o_side = r_side[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/syb_cordic.sv -----
`default_nettype none
module syb_cordic
    import syb_pkg::*;
#(
    parameter int STEPS  = CORDIC_STEPS_DEF,
    parameter int SIDE_W = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_pipe_ctl           i_ctl,
    input  wire logic signed [CW-1:0] i_x,
    input  wire logic signed [CW-1:0] i_y,
    input  wire logic signed [ZW-1:0] i_z,
    input  wire logic [SIDE_W-1:0]   i_side,
    output logic                     o_vld,
    output logic signed [ZW-1:0]     o_z,
    output logic [SIDE_W-1:0]        o_side
);

    logic signed [CW-1:0] r_x    [STEPS];
    logic signed [CW-1:0] r_y    [STEPS];
    logic signed [ZW-1:0] r_z    [STEPS];
    logic [SIDE_W-1:0]    r_side [STEPS];
    logic                 r_vld  [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic signed [CW-1:0] x, y, n_x, n_y;
        logic signed [ZW-1:0] z, n_z;
        assign x = (k == 0) ? i_x : r_x[k-1];
        assign y = (k == 0) ? i_y : r_y[k-1];
        assign z = (k == 0) ? i_z : r_z[k-1];

        always_comb begin
            // shifts floor toward minus infinity
            if (!y[CW-1] && (y != '0)) begin
                n_x = x + (y >>> k);
                n_y = y - (x >>> k);
                n_z = z + $signed(ZW'(atan_entry(k)));
            end else begin
                n_x = x - (y >>> k);
                n_y = y + (x >>> k);
                n_z = z - $signed(ZW'(atan_entry(k)));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.adv) begin
                r_vld[k] <= (k == 0) ? i_ctl.vld : r_vld[k-1];
            end
            if (i_ctl.adv) begin
                r_x[k]    <= n_x;
                r_y[k]    <= n_y;
                r_z[k]    <= n_z;
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_z    = r_z[STEPS-1];
    assign o_side = r_side[STEPS-1];

endmodule
`default_nettype wire

// ----- rtl/signed_yaw_from_basis.sv -----
// channel | valid       | stall        | payload
// input   | i_in_valid  | o_in_stall   | i_src_*, i_tgt_*, i_fwd_*, i_right_*
// output  | o_out_valid | i_out_stall  | o_yaw_centideg, o_found
// config  | i_cfg_wr_en | -            | i_cfg_index, i_cfg_data
//
// One item per cycle while not stalled: three front stages, four
// isqrt stages, five normalize stages, one CORDIC iteration per stage, two output stages.
// Reset clears valid bits and config registers (synchronous, active low).
// The pipeline advances as a whole whenever the output register is empty or
// its transfer completes; o_in_stall is the inverse of that advance.
`default_nettype none
module signed_yaw_from_basis
    import syb_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int POS_WIDTH    = POS_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic signed [POS_WIDTH-1:0] i_src_x,
    input  wire logic signed [POS_WIDTH-1:0] i_src_y,
    input  wire logic signed [POS_WIDTH-1:0] i_src_z,
    input  wire logic signed [POS_WIDTH-1:0] i_tgt_x,
    input  wire logic signed [POS_WIDTH-1:0] i_tgt_y,
    input  wire logic signed [POS_WIDTH-1:0] i_tgt_z,
    input  wire logic signed [BASIS_W-1:0]   i_fwd_x,
    input  wire logic signed [BASIS_W-1:0]   i_fwd_y,
    input  wire logic signed [BASIS_W-1:0]   i_fwd_z,
    input  wire logic signed [BASIS_W-1:0]   i_right_x,
    input  wire logic signed [BASIS_W-1:0]   i_right_y,
    input  wire logic signed [BASIS_W-1:0]   i_right_z,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic signed [YAW_W-1:0]          o_yaw_centideg,
    output logic                             o_found
);

    localparam int DW   = POS_WIDTH + 1;
    localparam int PW   = DW + BASIS_W;
    localparam int SW   = PW + 2;
    localparam int XW   = SW + LEN_W + 1;
    localparam int SH_W = $clog2(XW);
    localparam int YW   = ZW + 1 - 16;

    // configuration
    logic [MAXYAW_W-1:0] r_max_abs_yaw;
    logic                r_flatten_z;
    logic [TOL_W-1:0]    r_zero_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_abs_yaw <= '0;
            r_flatten_z   <= 1'b0;
            r_zero_tol    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MAX_ABS_YAW:    r_max_abs_yaw <= i_cfg_data[MAXYAW_W-1:0];
                CFG_FLATTEN_Z:      r_flatten_z   <= i_cfg_data[0];
                CFG_ZERO_TOLERANCE: r_zero_tol    <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic r_out_vld;
    assign adv        = !r_out_vld || !i_out_stall;
    assign o_in_stall = !adv;

    // stage 1: direction, flatten
    logic                      r_s1_vld;
    logic signed [DW-1:0]      r_s1_dx, r_s1_dy, r_s1_dz;
    logic signed [BASIS_W-1:0] r_s1_fx, r_s1_fy, r_s1_fz, r_s1_rx, r_s1_ry, r_s1_rz;

    // stage 2: products, squares, zero test
    logic                 r_s2_vld, r_s2_nz;
    logic signed [PW-1:0] r_s2_pf0, r_s2_pf1, r_s2_pf2, r_s2_pr0, r_s2_pr1, r_s2_pr2;
    logic [SQ_W-1:0]      r_s2_qf0, r_s2_qf1, r_s2_qf2, r_s2_qr0, r_s2_qr1, r_s2_qr2;

    // stage 3: dot products, squared lengths
    logic                 r_s3_vld, r_s3_nz;
    logic signed [SW-1:0] r_s3_dotf, r_s3_dotr;
    logic [SQ_W-1:0]      r_s3_sf, r_s3_sr;

    logic [DW-1:0] m_dx, m_dy, m_dz;
    always_comb begin
        m_dx = r_s1_dx[DW-1] ? DW'(-r_s1_dx) : DW'(r_s1_dx);
        m_dy = r_s1_dy[DW-1] ? DW'(-r_s1_dy) : DW'(r_s1_dy);
        m_dz = r_s1_dz[DW-1] ? DW'(-r_s1_dz) : DW'(r_s1_dz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= i_in_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
        if (adv) begin
            r_s1_dx <= DW'(i_tgt_x) - DW'(i_src_x);
            r_s1_dy <= DW'(i_tgt_y) - DW'(i_src_y);
            r_s1_dz <= r_flatten_z ? '0 : DW'(i_tgt_z) - DW'(i_src_z);
            r_s1_fx <= i_fwd_x;
            r_s1_fy <= i_fwd_y;
            r_s1_fz <= r_flatten_z ? '0 : i_fwd_z;
            r_s1_rx <= i_right_x;
            r_s1_ry <= i_right_y;
            r_s1_rz <= r_flatten_z ? '0 : i_right_z;

            r_s2_nz  <= !((m_dx <= DW'(r_zero_tol)) && (m_dy <= DW'(r_zero_tol)) &&
                          (m_dz <= DW'(r_zero_tol)));
            r_s2_pf0 <= PW'(r_s1_dx) * PW'(r_s1_fx);
            r_s2_pf1 <= PW'(r_s1_dy) * PW'(r_s1_fy);
            r_s2_pf2 <= PW'(r_s1_dz) * PW'(r_s1_fz);
            r_s2_pr0 <= PW'(r_s1_dx) * PW'(r_s1_rx);
            r_s2_pr1 <= PW'(r_s1_dy) * PW'(r_s1_ry);
            r_s2_pr2 <= PW'(r_s1_dz) * PW'(r_s1_rz);
            r_s2_qf0 <= SQ_W'(SQ_W'(r_s1_fx) * SQ_W'(r_s1_fx));
            r_s2_qf1 <= SQ_W'(SQ_W'(r_s1_fy) * SQ_W'(r_s1_fy));
            r_s2_qf2 <= SQ_W'(SQ_W'(r_s1_fz) * SQ_W'(r_s1_fz));
            r_s2_qr0 <= SQ_W'(SQ_W'(r_s1_rx) * SQ_W'(r_s1_rx));
            r_s2_qr1 <= SQ_W'(SQ_W'(r_s1_ry) * SQ_W'(r_s1_ry));
            r_s2_qr2 <= SQ_W'(SQ_W'(r_s1_rz) * SQ_W'(r_s1_rz));

            r_s3_nz   <= r_s2_nz;
            r_s3_dotf <= SW'(r_s2_pf0) + SW'(r_s2_pf1) + SW'(r_s2_pf2);
            r_s3_dotr <= SW'(r_s2_pr0) + SW'(r_s2_pr1) + SW'(r_s2_pr2);
            r_s3_sf   <= r_s2_qf0 + r_s2_qf1 + r_s2_qf2;
            r_s3_sr   <= r_s2_qr0 + r_s2_qr1 + r_s2_qr2;
        end
    end

    // stages 4..7: lengths
    t_pipe_ctl          sq_ctl;
    logic               sq_vld;
    logic [LEN_W-1:0]   sq_nf, sq_nr;
    logic [2*SW:0]      sq_side;
    assign sq_ctl = '{adv: adv, vld: r_s3_vld};

    syb_isqrt #(
        .SIDE_W (2 * SW + 1)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sq_ctl),
        .i_sf    (r_s3_sf),
        .i_sr    (r_s3_sr),
        .i_side  ({r_s3_nz, r_s3_dotf, r_s3_dotr}),
        .o_vld   (sq_vld),
        .o_nf    (sq_nf),
        .o_nr    (sq_nr),
        .o_side  (sq_side)
    );

    logic signed [SW-1:0] sq_dotf, sq_dotr;
    logic                 sq_nz;
    logic [LEN_W-1:0]     len_f, len_r;
    assign {sq_nz, sq_dotf, sq_dotr} = sq_side;
    assign len_f = (sq_nf == '0) ? LEN_W'(1) : sq_nf;
    assign len_r = (sq_nr == '0) ? LEN_W'(1) : sq_nr;

    // stage 8: scaled projections
    logic                 r_s8_vld, r_s8_nz;
    logic signed [XW-1:0] r_s8_px, r_s8_py;
    // stage 9: magnitudes
    logic                 r_s9_vld, r_s9_nz, r_s9_xn, r_s9_yn;
    logic [XW-1:0]        r_s9_ax, r_s9_ay;
    // stage 10: shift amount
    logic                 r_s10_vld, r_s10_nz, r_s10_xn, r_s10_yn;
    logic [XW-1:0]        r_s10_ax, r_s10_ay;
    logic [SH_W-1:0]      r_s10_sh;
    // stage 11: normalized signed pair
    logic                 r_s11_vld, r_s11_nz, r_s11_zp;
    logic signed [CW-1:0] r_s11_x, r_s11_y;
    // stage 12: half-turn pre-rotation
    logic                 r_s12_vld, r_s12_nz, r_s12_zp;
    logic signed [CW-1:0] r_s12_x, r_s12_y;
    logic signed [ZW-1:0] r_s12_z;

    logic [XW-1:0]   or_mag;
    logic [SH_W-1:0] n_sh;
    always_comb begin
        or_mag = r_s9_ax | r_s9_ay;
        n_sh   = '0;
        for (int k = NORM_W; k < XW; k++) begin
            if (or_mag[k]) n_sh = SH_W'(k - NORM_W + 1);
        end
    end

    logic [XW-1:0] ax_s, ay_s;
    assign ax_s = r_s10_ax >> r_s10_sh;
    assign ay_s = r_s10_ay >> r_s10_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_s12_vld <= 1'b0;
        end else if (adv) begin
            r_s8_vld  <= sq_vld;
            r_s9_vld  <= r_s8_vld;
            r_s10_vld <= r_s9_vld;
            r_s11_vld <= r_s10_vld;
            r_s12_vld <= r_s11_vld;
        end
        if (adv) begin
            r_s8_nz <= sq_nz;
            r_s8_px <= XW'(sq_dotf) * XW'($signed({1'b0, len_r}));
            r_s8_py <= XW'(sq_dotr) * XW'($signed({1'b0, len_f}));

            r_s9_nz <= r_s8_nz;
            r_s9_xn <= r_s8_px[XW-1];
            r_s9_yn <= r_s8_py[XW-1];
            r_s9_ax <= r_s8_px[XW-1] ? XW'(-r_s8_px) : XW'(r_s8_px);
            r_s9_ay <= r_s8_py[XW-1] ? XW'(-r_s8_py) : XW'(r_s8_py);

            r_s10_nz <= r_s9_nz;
            r_s10_xn <= r_s9_xn;
            r_s10_yn <= r_s9_yn;
            r_s10_ax <= r_s9_ax;
            r_s10_ay <= r_s9_ay;
            r_s10_sh <= n_sh;

            r_s11_nz <= r_s10_nz;
            r_s11_zp <= (ax_s == '0) && (ay_s == '0);
            r_s11_x  <= r_s10_xn ? -$signed(CW'(ax_s[NORM_W-1:0]))
                                 :  $signed(CW'(ax_s[NORM_W-1:0]));
            r_s11_y  <= r_s10_yn ? -$signed(CW'(ay_s[NORM_W-1:0]))
                                 :  $signed(CW'(ay_s[NORM_W-1:0]));

            r_s12_nz <= r_s11_nz;
            r_s12_zp <= r_s11_zp;
            if (r_s11_x[CW-1]) begin
                r_s12_x <= -r_s11_x;
                r_s12_y <= -r_s11_y;
                r_s12_z <= r_s11_y[CW-1] ? -$signed(ZW'(HALF_TURN_FX))
                                         :  $signed(ZW'(HALF_TURN_FX));
            end else begin
                r_s12_x <= r_s11_x;
                r_s12_y <= r_s11_y;
                r_s12_z <= '0;
            end
        end
    end

    // CORDIC vectoring, one iteration per stage
    t_pipe_ctl            cd_ctl;
    logic                 cd_vld;
    logic signed [ZW-1:0] cd_z;
    logic [1:0]           cd_side;
    assign cd_ctl = '{adv: adv, vld: r_s12_vld};

    syb_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (2)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cd_ctl),
        .i_x     (r_s12_x),
        .i_y     (r_s12_y),
        .i_z     (r_s12_z),
        .i_side  ({r_s12_nz, r_s12_zp}),
        .o_vld   (cd_vld),
        .o_z     (cd_z),
        .o_side  (cd_side)
    );

    // round to centidegrees, halves away from zero, then saturate
    logic signed [ZW:0]   z_pos, z_neg;
    logic signed [YW-1:0] yaw_r;
    logic signed [YAW_W-1:0] n_yaw_sat;
    always_comb begin
        z_pos = (ZW + 1)'(cd_z) + (ZW + 1)'(32768);
        z_neg = -(ZW + 1)'(cd_z) + (ZW + 1)'(32768);
        if (!cd_z[ZW-1]) yaw_r = YW'(z_pos >>> 16);
        else             yaw_r = -YW'(z_neg >>> 16);
        if (yaw_r > YW'(YAW_LIM))       n_yaw_sat = YAW_W'(YAW_LIM);
        else if (yaw_r < -YW'(YAW_LIM)) n_yaw_sat = -YAW_W'(YAW_LIM);
        else                            n_yaw_sat = YAW_W'(yaw_r);
    end

    logic                    r_sr_vld, r_sr_nz, r_sr_zp;
    logic signed [YAW_W-1:0] r_sr_yaw;

    // user clamp and final select
    logic signed [YAW_W:0]   lim, yaw_e;
    logic signed [YAW_W-1:0] n_yaw;
    always_comb begin
        lim   = $signed((YAW_W + 1)'(r_max_abs_yaw));
        yaw_e = (YAW_W + 1)'(r_sr_yaw);
        n_yaw = r_sr_yaw;
        if (!r_sr_nz || r_sr_zp) begin
            n_yaw = '0;
        end else if (r_max_abs_yaw != '0) begin
            if (yaw_e > lim)       n_yaw = YAW_W'(lim);
            else if (yaw_e < -lim) n_yaw = YAW_W'(-lim);
        end
    end

    logic                    r_out_found;
    logic signed [YAW_W-1:0] r_out_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_sr_vld  <= cd_vld;
            r_out_vld <= r_sr_vld;
        end
        if (adv) begin
            r_sr_nz     <= cd_side[1];
            r_sr_zp     <= cd_side[0];
            r_sr_yaw    <= n_yaw_sat;
            r_out_found <= r_sr_nz;
            r_out_yaw   <= n_yaw;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_yaw_centideg = r_out_yaw;
    assign o_found        = r_out_found;

endmodule
`default_nettype wire

// ----- rtl/syb_checker.sv -----
`default_nettype none
module syb_checker
    import syb_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_in_stall,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_stall,
    input wire logic signed [YAW_W-1:0] o_yaw_centideg,
    input wire logic                    o_found
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_yaw_centideg) && $stable(o_found)))
        else $error("stalled output changed");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_yaw_centideg == '0))
        else $error("nonzero yaw without a direction");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_yaw_centideg <= YAW_W'(YAW_LIM)) &&
                         (o_yaw_centideg >= -YAW_W'(YAW_LIM))))
        else $error("yaw out of range");

endmodule

bind signed_yaw_from_basis syb_checker u_syb_checker (.*);
`default_nettype wire

// ----- bench/signed_yaw_from_basis_test.sv -----
`timescale 1ns / 1ps
module signed_yaw_from_basis_test;
    import syb_pkg::*;

    localparam int PW = POS_WIDTH_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped index
    localparam int LATENCY = 14 + CORDIC_STEPS_DEF;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [PW-1:0]      sx, sy, sz, tx, ty, tz;
        logic signed [BASIS_W-1:0] fx, fy, fz, rx, ry, rz;
    } t_query;

    typedef struct {
        logic signed [YAW_W-1:0] yaw;
        logic                    found;
    } t_bearing;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 0;
    logic o_in_stall;
    logic signed [PW-1:0] i_src_x = 0, i_src_y = 0, i_src_z = 0;
    logic signed [PW-1:0] i_tgt_x = 0, i_tgt_y = 0, i_tgt_z = 0;
    logic signed [BASIS_W-1:0] i_fwd_x = 0, i_fwd_y = 0, i_fwd_z = 0;
    logic signed [BASIS_W-1:0] i_right_x = 0, i_right_y = 0, i_right_z = 0;
    logic o_out_valid;
    logic i_out_stall = 0;
    logic signed [YAW_W-1:0] o_yaw_centideg;
    logic o_found;

    signed_yaw_from_basis dut (.*);

    always #4 i_clk = ~i_clk;

    longint yaw_limit = 0;
    bit     flat = 0;
    longint tol = 0;

    t_query   pending_queries[$];
    t_bearing expected_bearings[$];
    t_query   cur;
    bit       steady = 0;
    int       errors = 0;
    int       cycles = 0;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic longint root_len(input longint a, input longint b, input longint c);
        longint v, res, bt;
        v = (a * a + b * b + c * c) & 64'hFFFF_FFFF;
        res = 0;
        bt = 64'd1 << 30;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return (res == 0) ? 1 : res;
    endfunction

    function automatic t_bearing bearing_of(input t_query q);
        longint dx, dy, dz, fx, fy, fz, rx, ry, rz, px, py, ax, ay, x, y, z, xs, ys, yaw;
        t_bearing b;
        dx = longint'(q.tx) - longint'(q.sx);
        dy = longint'(q.ty) - longint'(q.sy);
        dz = longint'(q.tz) - longint'(q.sz);
        fx = q.fx; fy = q.fy; fz = q.fz;
        rx = q.rx; ry = q.ry; rz = q.rz;
        if (flat) begin
            dz = 0; fz = 0; rz = 0;
        end
        b.found = 0;
        b.yaw = 0;
        if ((dx < 0 ? -dx : dx) <= tol && (dy < 0 ? -dy : dy) <= tol
                && (dz < 0 ? -dz : dz) <= tol)
            return b;
        px = (dx * fx + dy * fy + dz * fz) * root_len(rx, ry, rz);
        py = (dx * rx + dy * ry + dz * rz) * root_len(fx, fy, fz);
        ax = px < 0 ? -px : px;
        ay = py < 0 ? -py : py;
        while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
            ax = ax >> 1;
            ay = ay >> 1;
        end
        if (ax == 0 && ay == 0) begin
            yaw = 0;
        end else begin
            x = px < 0 ? -ax : ax;
            y = py < 0 ? -ay : ay;
            z = 0;
            if (x < 0) begin
                z = (y >= 0) ? longint'(HALF_TURN_FX) : -longint'(HALF_TURN_FX);
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys; y = y - xs; z = z + longint'(atan_entry(i));
                end else begin
                    x = x - ys; y = y + xs; z = z - longint'(atan_entry(i));
                end
            end
            yaw = (z >= 0) ? ((z + 32768) >>> 16) : -(((-z) + 32768) >>> 16);
            if (yaw > YAW_LIM) yaw = YAW_LIM;
            if (yaw < -YAW_LIM) yaw = -YAW_LIM;
        end
        if (yaw_limit != 0) begin
            if (yaw > yaw_limit) yaw = yaw_limit;
            if (yaw < -yaw_limit) yaw = -yaw_limit;
        end
        b.yaw = yaw[YAW_W-1:0];
        b.found = 1;
        return b;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_bearings.push_back(bearing_of(cur));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_queries.size() > 0 && (steady || $urandom_range(99) >= 23)) begin
                    cur = pending_queries.pop_front();
                    i_src_x <= cur.sx; i_src_y <= cur.sy; i_src_z <= cur.sz;
                    i_tgt_x <= cur.tx; i_tgt_y <= cur.ty; i_tgt_z <= cur.tz;
                    i_fwd_x <= cur.fx; i_fwd_y <= cur.fy; i_fwd_z <= cur.fz;
                    i_right_x <= cur.rx; i_right_y <= cur.ry; i_right_z <= cur.rz;
                    i_in_valid <= 1;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        t_bearing e;
        i_out_stall <= steady ? 1'b0 : ($urandom_range(99) < 23);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bearings.size() == 0) begin
                report("result with nothing expected");
            end else begin
                e = expected_bearings.pop_front();
                if (o_found !== e.found)
                    report($sformatf("found %0b, want %0b", o_found, e.found));
                if (o_yaw_centideg !== e.yaw)
                    report($sformatf("yaw %0d, want %0d", o_yaw_centideg, e.yaw));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("signed_yaw_from_basis regression: fail");
            $finish;
        end
    end

    function automatic t_query mk(input longint sx, sy, sz, tx, ty, tz,
                                  input longint fx, fy, fz, rx, ry, rz);
        t_query q;
        q.sx = PW'(sx); q.sy = PW'(sy); q.sz = PW'(sz);
        q.tx = PW'(tx); q.ty = PW'(ty); q.tz = PW'(tz);
        q.fx = BASIS_W'(fx); q.fy = BASIS_W'(fy); q.fz = BASIS_W'(fz);
        q.rx = BASIS_W'(rx); q.ry = BASIS_W'(ry); q.rz = BASIS_W'(rz);
        return q;
    endfunction

    function automatic t_query random_query();
        t_query q;
        int kind;
        kind = $urandom_range(9);
        q = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (kind >= 3) begin
            // nearby target, sometimes within the zero band
            q.tx = PW'(q.sx + ($urandom_range(kind >= 7 ? 600 : 40000)
                               - (kind >= 7 ? 300 : 20000)));
            q.ty = PW'(q.sy + ($urandom_range(kind >= 7 ? 600 : 40000)
                               - (kind >= 7 ? 300 : 20000)));
            q.tz = PW'(q.sz + ($urandom_range(600) - 300));
        end
        if (kind >= 5) begin
            // plausible basis: forward mostly horizontal, right perpendicular
            q.fx = BASIS_W'($urandom_range(32767) - 16384);
            q.fy = BASIS_W'($urandom_range(32767) - 16384);
            q.fz = BASIS_W'($urandom_range(200) - 100);
            q.rx = -q.fy;
            q.ry = q.fx;
            q.rz = 0;
        end
        return q;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        if (idx == CFG_MAX_ABS_YAW) yaw_limit = val & 16'h7FFF;
        else if (idx == CFG_FLATTEN_Z) flat = val[0];
        else if (idx == CFG_ZERO_TOLERANCE) tol = val & 8'hFF;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input longint lim, input longint fl, input longint tl);
        @(posedge i_clk);
        write_reg(CFG_MAX_ABS_YAW, lim);
        write_reg(CFG_FLATTEN_Z, fl);
        write_reg(CFG_ZERO_TOLERANCE, tl);
        write_reg(CFG_SPARE, $urandom);
        i_cfg_wr_en <= 0;
    endtask

    task automatic drain();
        wait (pending_queries.size() == 0 && !i_in_valid && expected_bearings.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) pending_queries.push_back(random_query());
        drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // defaults: no clamp, no flattening, exact zero test
        set_regs(0, 0, 0);
        pending_queries.push_back(mk(5, 5, 5, 5, 5, 5, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, 1, 0, 0, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(8388607, 8388607, 8388607, -8388608, -8388608,
                                     -8388608, 16383, 16383, 16383, -16384, -16384, -16384));
        pending_queries.push_back(mk(-8388608, -8388608, -8388608, 8388607, 8388607,
                                     8388607, -16384, 16383, 0, 16383, -16384, 0));
        pending_queries.push_back(mk(0, 0, 0, 100, 100, 0, 0, 0, 0, 0, 0, 0));
        pending_queries.push_back(mk(0, 0, 0, -1000, 0, 0, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, -1000, -1, 0, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, 0, 1000, 0, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, 0, -1000, 0, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, 0, 0, 500, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, 700, 700, 0, 16383, 0, 0, 0, -16384, 0));
        drain();

        // tolerance band edges, flattening and clamp
        set_regs(5000, 1, 255);
        pending_queries.push_back(mk(0, 0, 0, 255, -255, 9000, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, 256, 0, 0, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, -255, -256, 0, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, 0, 9000, 0, 16383, 0, 16000, 0, 16383, 16000));
        pending_queries.push_back(mk(0, 0, 0, -9000, -10, 0, 16383, 0, 0, 0, 16383, 0));
        pending_queries.push_back(mk(0, 0, 0, 400, 0, 0, 0, 0, 16383, 0, 0, 16383));
        drain();

        steady = 1;
        set_regs(0, 0, 0);
        run_random(100);
        steady = 0;
        set_regs(18000, 0, 255);
        run_random(90);
        set_regs(32767, 1, 0);
        run_random(90);
        set_regs(1, 1, 128);
        run_random(80);
        set_regs(9000, 0, 10);
        run_random(100);
        set_regs($urandom_range(18000), $urandom_range(1), $urandom_range(255));
        run_random(90);

        if (errors == 0)
            $display("signed_yaw_from_basis regression: pass");
        else
            $display("signed_yaw_from_basis regression: fail");
        $finish;
    end

endmodule
